// ----- sv/lvpr_pkg.sv -----
// Shared constants and types for the longest valid parenthesis run block.
package lvpr_pkg;

    // Longest string that is taken; later characters only set the overflow flag.
    localparam int MAX_LEN     = 1024;
    // Stack cells: the base entry plus one for every open.
    localparam int DEPTH       = MAX_LEN + 1;
    // Positions are held as position + 1, so the -1 base is held as zero.
    localparam int POS_W       = $clog2(MAX_LEN + 1);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int OUT_W       = 11;
    localparam int LONGEST_MAX = 2047;
    localparam int BEST_W      = (POS_W > OUT_W) ? POS_W : OUT_W;
    localparam int CHAR_W      = 8;
    localparam logic [CHAR_W-1:0] OPEN_CHAR = 8'h28;

    // Per-cell shift control.
    typedef struct packed {
        logic take_above;  // load the neighbor nearer the top (push)
        logic take_below;  // load the neighbor further from the top (pop)
    } t_cell_ctl;

    // One result beat.
    typedef struct packed {
        logic [OUT_W-1:0] longest;
        logic             end_of_string;
        logic             overflow;
    } t_result;

endpackage

// ----- sv/lvpr_cell.sv -----
// One entry of the shifting position stack.
module lvpr_cell (
    input  logic                     i_clk,
    input  lvpr_pkg::t_cell_ctl      i_ctl,
    input  logic [lvpr_pkg::POS_W-1:0] i_above,
    input  logic [lvpr_pkg::POS_W-1:0] i_below,
    output logic [lvpr_pkg::POS_W-1:0] o_value
);
    import lvpr_pkg::*;

    logic [POS_W-1:0] r_value;
    logic [POS_W-1:0] n_value;

    // A push moves every entry one cell down, a pop one cell up.
    always_comb begin
        n_value = r_value;
        if (i_ctl.take_above) begin
            n_value = i_above;
        end else if (i_ctl.take_below) begin
            n_value = i_below;
        end
    end

    // Payload only: entries are never read before they are written.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ----- sv/lvpr_skid.sv -----
// Two-entry output stage that parts the result stream from the stack logic.
module lvpr_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lvpr_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    output lvpr_pkg::t_result o_data,
    input  logic              i_ready
);
    import lvpr_pkg::*;

    logic    r_main_v;
    logic    r_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    w_accept;
    logic    w_drain;

    assign o_ready  = !r_skid_v;
    assign w_accept = i_valid && !r_skid_v;
    assign w_drain  = r_main_v && i_ready;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_drain || !r_main_v) begin
            if (r_skid_v) begin
                r_main_v <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_v <= 1'b1;
        end
    end

    // Payload: the skid entry refills the main entry when it frees up.
    always_ff @(posedge i_clk) begin
        if (w_drain || !r_main_v) begin
            if (r_skid_v) begin
                r_main <= r_skid;
            end else begin
                r_main <= i_data;
            end
        end else if (w_accept) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_main_v;
    assign o_data  = r_main;

endmodule

// ----- sv/longest_valid_paren_run.sv -----
// Top level: longest well-formed parenthesis run over a character stream.
//
//  Channel  | Direction | tdata (low bit up)       | tuser     | tlast
//  ---------+-----------+--------------------------+-----------+--------------
//  i_s_*    | in        | char_byte[7:0]           | first     | last
//  o_m_*    | out       | longest[10:0], 5'b0 pad  | overflow  | end_of_string
//
// One character is taken per cycle unless the output stage is full, and its
// result beat is registered there. The stack is a row of 1025 cells with the
// top in cell 0; a whole-row shift lets the next character follow at once.
// Reset sets the count to one, clears position, best length and overflow, and
// holds the base at zero until the first beat writes cell 0; the cells need none.
// A two-entry output stage keeps accepting while a result waits on i_m_tready;
// the input stalls only when both entries hold results.
module longest_valid_paren_run (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_byte
    input  logic        i_s_tuser,   // [0] first
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [10:0] longest, [15:11] zero
    output logic        o_m_tuser,   // [0] overflow
    output logic        o_m_tlast
);
    import lvpr_pkg::*;

    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [BEST_W-1:0] r_best;
    logic [BEST_W-1:0] n_best;
    logic              r_ovf;
    logic              n_ovf;
    logic              r_base_zero;

    logic              w_accept;
    logic              w_skid_ready;
    logic [CNT_W-1:0]  w_cnt_eff;
    logic [POS_W-1:0]  w_pos_eff;
    logic [BEST_W-1:0] w_best_eff;
    logic              w_ovf_eff;
    logic [POS_W-1:0]  w_here;
    logic [POS_W-1:0]  w_run;
    logic              w_push;
    logic              w_pop;
    logic              w_load;
    t_result           w_result;

    logic [POS_W-1:0]  w_val [DEPTH];
    t_cell_ctl         w_ctl [DEPTH];

    assign o_s_tready = w_skid_ready;
    assign w_accept   = i_s_tvalid && w_skid_ready;

    // A first flag clears the string state ahead of its own character.
    assign w_cnt_eff  = i_s_tuser ? CNT_W'(1) : r_cnt;
    assign w_pos_eff  = i_s_tuser ? '0 : r_pos;
    assign w_best_eff = i_s_tuser ? '0 : r_best;
    assign w_ovf_eff  = i_s_tuser ? 1'b0 : r_ovf;
    assign w_here     = w_pos_eff + POS_W'(1);
    // Only used when at least two entries are stacked, so cell 1 is valid.
    assign w_run      = w_here - w_val[1];

    // Decide the stack operation and the next scalar state.
    always_comb begin
        n_cnt  = w_cnt_eff;
        n_pos  = w_pos_eff;
        n_best = w_best_eff;
        n_ovf  = w_ovf_eff;
        w_push = 1'b0;
        w_pop  = 1'b0;
        w_load = 1'b0;
        if (32'(w_pos_eff) >= MAX_LEN) begin
            n_ovf = 1'b1;
        end else begin
            n_pos = w_here;
            if (i_s_tdata == OPEN_CHAR) begin
                if (32'(w_cnt_eff) < DEPTH) begin
                    w_push = 1'b1;
                    n_cnt  = w_cnt_eff + CNT_W'(1);
                end
            end else if (w_cnt_eff <= CNT_W'(1)) begin
                // The pop would empty the stack: the close becomes the new base.
                w_load = 1'b1;
                n_cnt  = CNT_W'(1);
            end else begin
                w_pop = 1'b1;
                n_cnt = w_cnt_eff - CNT_W'(1);
                if (BEST_W'(w_run) > w_best_eff) begin
                    n_best = BEST_W'(w_run);
                end
            end
        end
    end

    // Scalar state; the first beat after reset always writes cell 0, which
    // ends the stretch where the base reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= CNT_W'(1);
            r_pos       <= '0;
            r_best      <= '0;
            r_ovf       <= 1'b0;
            r_base_zero <= 1'b1;
        end else if (w_accept) begin
            r_cnt       <= n_cnt;
            r_pos       <= n_pos;
            r_best      <= n_best;
            r_ovf       <= n_ovf;
            r_base_zero <= 1'b0;
        end
    end

    // Row of stack cells; the top cell also takes the base on a replacing close,
    // and after a first flag or reset the zero base moves into cell 1 on a push.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [POS_W-1:0] w_above;
            logic [POS_W-1:0] w_below;
            if (gi == 0) begin : g_top
                assign w_above = w_here;
                assign w_ctl[gi].take_above = w_accept && (w_push || w_load);
            end else if (gi == 1) begin : g_second
                assign w_above = (i_s_tuser || r_base_zero) ? '0 : w_val[0];
                assign w_ctl[gi].take_above = w_accept && w_push;
            end else begin : g_rest
                assign w_above = w_val[gi-1];
                assign w_ctl[gi].take_above = w_accept && w_push;
            end
            if (gi == DEPTH - 1) begin : g_bottom
                assign w_below = '0;
            end else begin : g_inner
                assign w_below = w_val[gi+1];
            end
            assign w_ctl[gi].take_below = w_accept && w_pop;

            lvpr_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[gi]),
                .i_above (w_above),
                .i_below (w_below),
                .o_value (w_val[gi])
            );
        end
    endgenerate

    // Result beat built from the updated state; longest saturates at 2047.
    always_comb begin
        if (n_best > BEST_W'(LONGEST_MAX)) begin
            w_result.longest = OUT_W'(LONGEST_MAX);
        end else begin
            w_result.longest = n_best[OUT_W-1:0];
        end
        w_result.end_of_string = i_s_tlast;
        w_result.overflow      = n_ovf;
    end

    t_result w_out;

    lvpr_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_data  (w_result),
        .o_ready (w_skid_ready),
        .o_valid (o_m_tvalid),
        .o_data  (w_out),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = {(16 - OUT_W)'(0), w_out.longest};
    assign o_m_tuser = w_out.overflow;
    assign o_m_tlast = w_out.end_of_string;

endmodule

// ----- tb/sv/longest_valid_paren_run_tb.sv -----
// Self-checking testbench for the longest valid parenthesis run block.
`timescale 1ns / 100ps

module longest_valid_paren_run_tb;
    import lvpr_pkg::*;

    // Tracks the parenthesis stack of the current string and queues the result
    // beat that each accepted character should produce.
    class paren_run_tracker;
        t_result            pending_results[$];
        logic [POS_W-1:0]   base_cells[DEPTH];
        logic [CNT_W-1:0]   cells_used;
        logic [POS_W-1:0]   char_pos;
        logic [BEST_W-1:0]  best_run;
        bit                 overflowed;
        int unsigned        mismatches;
        int unsigned        chars_taken;
        int unsigned        beats_checked;
        int unsigned        overflow_beats;

        // Reset leaves the block in the same state as a first flag does.
        function new();
            mismatches     = 0;
            chars_taken    = 0;
            beats_checked  = 0;
            overflow_beats = 0;
            clear_string();
        endfunction

        function void clear_string();
            base_cells[0] = '0;
            cells_used    = CNT_W'(1);
            char_pos      = '0;
            best_run      = '0;
            overflowed    = 1'b0;
        endfunction

        // Positions are kept as position + 1, so the base before the run is zero.
        function void note_char(input logic [7:0] c, input bit first, input bit last);
            logic [POS_W-1:0]  here;
            logic [BEST_W-1:0] run;
            t_result           beat;
            chars_taken++;
            if (first) begin
                clear_string();
            end
            if (char_pos >= MAX_LEN) begin
                // Past the length limit only the flag moves.
                overflowed = 1'b1;
            end else begin
                here = char_pos + 1'b1;
                if (c == OPEN_CHAR) begin
                    if (cells_used < DEPTH) begin
                        base_cells[cells_used] = here;
                        cells_used++;
                    end
                end else begin
                    if (cells_used > 0) begin
                        cells_used--;
                    end
                    if (cells_used == 0) begin
                        // An unmatched close becomes the new base.
                        base_cells[0] = here;
                        cells_used    = CNT_W'(1);
                    end else begin
                        run = here - base_cells[cells_used - 1];
                        if (run > best_run) begin
                            best_run = run;
                        end
                    end
                end
                char_pos++;
            end
            beat.longest       = (best_run > LONGEST_MAX) ? OUT_W'(LONGEST_MAX)
                                                          : OUT_W'(best_run);
            beat.end_of_string = last;
            beat.overflow      = overflowed;
            pending_results.push_back(beat);
        endfunction

        // Compares one output beat with the oldest queued result.
        function void check_beat(input logic [15:0] tdata, input logic tuser,
                                 input logic tlast);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing pending: longest %0d overflow %b last %b",
                         $time, tdata[OUT_W-1:0], tuser, tlast);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            beats_checked++;
            if (tuser === 1'b1) begin
                overflow_beats++;
            end
            if (tdata[OUT_W-1:0] !== want.longest) begin
                $display("%0t: longest mismatch: expected %0d, actual %0d",
                         $time, want.longest, tdata[OUT_W-1:0]);
                mismatches++;
            end
            if (tdata[15:OUT_W] !== '0) begin
                $display("%0t: tdata padding mismatch: expected 0, actual %h",
                         $time, tdata[15:OUT_W]);
                mismatches++;
            end
            if (tlast !== want.end_of_string) begin
                $display("%0t: end_of_string mismatch: expected %b, actual %b",
                         $time, want.end_of_string, tlast);
                mismatches++;
            end
            if (tuser !== want.overflow) begin
                $display("%0t: overflow mismatch: expected %b, actual %b",
                         $time, want.overflow, tuser);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] char_byte
    logic        i_s_tuser;   // [0] first
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // [10:0] longest, [15:11] zero
    logic        o_m_tuser;   // [0] overflow
    logic        o_m_tlast;

    paren_run_tracker tracker = new();
    bit               idle_on;
    int unsigned      strings_sent;

    longest_valid_paren_run DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Free-running clock, 10 ns period.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Upper bound on the run time, far above the slowest correct run.
    initial begin
        #5ms;
        $display("longest_valid_paren_run verification failed");
        $finish;
    end

    // The receiver stalls at random while idling is enabled.
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_tready = !(idle_on && ($urandom_range(0, 99) < 38));
        end
    end

    // Every accepted output beat is checked against the tracker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            tracker.check_beat(o_m_tdata, o_m_tuser, o_m_tlast);
        end
    end

    // Sends one character beat and notes it once it has been accepted.
    task automatic send_char(input logic [7:0] c, input bit first, input bit last);
        @(negedge i_clk);
        while (idle_on && ($urandom_range(0, 99) < 38)) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = c;
        i_s_tuser  = first;
        i_s_tlast  = last;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        tracker.note_char(c, first, last);
    endtask

    // Holds the input off until every queued result has come out.
    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (tracker.pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // A string of mostly opens and plain closes, with some arbitrary bytes and occasional
    // stray flags in the middle; a noisy string has arbitrary bytes and frequent flags.
    task automatic send_random_string(input int unsigned len, input bit noisy);
        logic [7:0] c;
        bit         first;
        bit         last;
        for (int unsigned k = 0; k < len; k++) begin
            if (noisy) begin
                c     = 8'($urandom_range(0, 255));
                first = $urandom_range(0, 3) == 0;
                last  = $urandom_range(0, 3) == 0;
            end else begin
                if ($urandom_range(0, 99) < 52) begin
                    c = OPEN_CHAR;
                end else if ($urandom_range(0, 99) < 65) begin
                    c = 8'h29;
                end else begin
                    c = 8'($urandom_range(0, 255));
                end
                first = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
                last  = (k == len - 1) ? ($urandom_range(0, 9) != 0)
                                       : ($urandom_range(0, 49) == 0);
            end
            send_char(c, first, last);
        end
        strings_sent++;
    endtask

    // Main sequence: reset, directed strings, the full-length string, random.
    initial begin
        int unsigned random_chars;
        int unsigned len;
        logic [7:0]  c;

        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = 1'b0;
        i_s_tlast    = 1'b0;
        idle_on      = 1'b1;
        strings_sent = 0;
        random_chars = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Straight after reset without a first flag; the reset base stands before the first
        // open, the first close ends a run, and the later closes only move the base.
        send_char(OPEN_CHAR, 1'b0, 1'b0);
        send_char(8'h29, 1'b0, 1'b0);
        send_char(8'h29, 1'b0, 1'b0);
        send_char(8'h00, 1'b0, 1'b1);
        // No first flag after a last: the string goes on.
        send_char(OPEN_CHAR, 1'b0, 1'b0);
        send_char(8'hFF, 1'b0, 1'b1);
        // Both flags on one beat make a one-character string.
        send_char(OPEN_CHAR, 1'b1, 1'b1);
        send_char(8'h29, 1'b1, 1'b1);
        // ")()())" with 8'h27 and 8'h2A, near the open code, as closes.
        send_char(8'h29, 1'b1, 1'b0);
        send_char(OPEN_CHAR, 1'b0, 1'b0);
        send_char(8'h27, 1'b0, 1'b0);
        send_char(OPEN_CHAR, 1'b0, 1'b0);
        send_char(8'h2A, 1'b0, 1'b0);
        send_char(8'h29, 1'b0, 1'b1);
        // "(()" and a string that starts with a close.
        send_char(OPEN_CHAR, 1'b1, 1'b0);
        send_char(OPEN_CHAR, 1'b0, 1'b0);
        send_char(8'h7F, 1'b0, 1'b1);
        send_char(8'h80, 1'b1, 1'b0);
        send_char(OPEN_CHAR, 1'b0, 1'b0);
        send_char(8'hD7, 1'b0, 1'b1);
        strings_sent += 7;

        // Let the output side empty before the long string starts.
        drain_results();

        // Fully nested string of maximum length, then characters past the limit.
        for (int unsigned k = 0; k < MAX_LEN / 2; k++) begin
            send_char(OPEN_CHAR, k == 0, 1'b0);
        end
        for (int unsigned k = 0; k < MAX_LEN / 2; k++) begin
            c = 8'($urandom_range(0, 255));
            if (c == OPEN_CHAR) begin
                c = 8'h29;
            end
            send_char(c, 1'b0, 1'b0);
        end
        for (int unsigned k = 0; k < 8; k++) begin
            send_char(8'($urandom_range(0, 255)), 1'b0, k == 7);
        end
        // A new string clears the overflow flag.
        send_char(OPEN_CHAR, 1'b1, 1'b0);
        send_char(8'h29, 1'b0, 1'b1);
        strings_sent += 2;

        // Random strings, with a stretch in the middle where neither side idles.
        while (random_chars < 450) begin
            idle_on = !(random_chars >= 150 && random_chars < 300);
            len = $urandom_range(1, 40);
            send_random_string(len, $urandom_range(0, 9) == 0);
            random_chars += len;
        end

        // Wait for the last results, then keep watching for stray beats.
        idle_on = 1'b1;
        drain_results();
        repeat (10) @(negedge i_clk);

        $display("Ran %0d strings, %0d characters, including a full-length nested string",
                 strings_sent, tracker.chars_taken);
        $display("and characters past the length limit; %0d result beats checked,",
                 tracker.beats_checked);
        $display("%0d of them flagged overflow.", tracker.overflow_beats);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("longest_valid_paren_run verification clean");
        end else begin
            $display("longest_valid_paren_run verification failed");
        end
        $finish;
    end

endmodule
